>>> design/openpgp_packet_deframer_core_defines.svh
// Assertion macros used by the deframer top level.
`ifndef OPENPGP_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define OPENPGP_PACKET_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk, idle during reset.
`define PGPD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, idle during reset.
`define PGPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pgpd_pkg.sv
// Types and codes shared by the OpenPGP packet deframer.
package pgpd_pkg;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_LEN1,
    PH_LEN2,
    PH_LENM,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    OK_TAG   = 2'd0,
    OK_BODY  = 2'd1,
    OK_END   = 2'd2,
    OK_ERROR = 2'd3
  } out_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_NO_MARKER = 2'd1,
    ERR_INDET     = 2'd2,
    ERR_TRUNC     = 2'd3
  } err_code_t;

  // Input kind flag
  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_EOF  = 1'b1;

  localparam logic [31:0] LEN_SAT = 32'hFFFF_FFFF;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] remaining;
    logic [31:0] acc;
    logic [2:0]  left;
    logic        partial;
    logic [31:0] total;
  } state_t;

  typedef struct packed {
    out_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    err_code_t   err;
    logic [31:0] len;
  } result_t;

endpackage

>>> design/pgpd_step.sv
// Per-byte next-state and result logic of the deframer.
module pgpd_step (
  input  pgpd_pkg::state_t  st,
  input  logic              kind,
  input  logic [7:0]        data_byte,
  output pgpd_pkg::state_t  st_nxt,
  output logic              res_valid,
  output pgpd_pkg::result_t res
);
  import pgpd_pkg::*;

  phase_t      ph;
  logic        b_lt192, b_le223, b_lt255;
  logic [31:0] len2, lenm_acc, part_len, total_inc, rem_dec;
  logic [2:0]  left_dec;
  logic        sb_go, sb_part, sb_end;
  logic [31:0] sb_len;

  // an undefined phase behaves as waiting for a tag
  always_comb begin
    unique case (st.phase)
      PH_LEN1, PH_LEN2, PH_LENM, PH_BODY: ph = st.phase;
      default:                            ph = PH_TAG;
    endcase
  end

  assign b_lt192   = data_byte < 8'd192;
  assign b_le223   = data_byte <= 8'd223;
  assign b_lt255   = data_byte != 8'd255;
  assign len2      = st.acc + {24'd0, data_byte} + 32'd192;
  assign lenm_acc  = {st.acc[23:0], data_byte};
  assign left_dec  = st.left - 3'd1;
  assign part_len  = 32'd1 << data_byte[4:0];
  assign total_inc = (st.total == LEN_SAT) ? st.total : st.total + 32'd1;
  assign rem_dec   = st.remaining - 32'd1;

  // a complete length header
  always_comb begin
    sb_go   = 1'b0;
    sb_len  = 32'd0;
    sb_part = 1'b0;
    if (kind == IN_BYTE) begin
      case (ph)
        PH_LEN1: begin
          if (b_lt192) begin
            sb_go  = 1'b1;
            sb_len = {24'd0, data_byte};
          end else if (!b_le223 && b_lt255) begin
            sb_go   = 1'b1;
            sb_len  = part_len;
            sb_part = 1'b1;
          end
        end
        PH_LEN2: begin
          sb_go  = 1'b1;
          sb_len = len2;
        end
        PH_LENM: begin
          sb_go  = (left_dec == 3'd0);
          sb_len = lenm_acc;
        end
        default: ;
      endcase
    end
  end

  assign sb_end = sb_go && (sb_len == 32'd0) && !sb_part;

  // next state
  always_comb begin
    st_nxt       = st;
    st_nxt.phase = ph;
    if (kind == IN_EOF) begin
      if (ph != PH_TAG) begin
        st_nxt.phase     = PH_TAG;
        st_nxt.remaining = 32'd0;
        st_nxt.acc       = 32'd0;
        st_nxt.left      = 3'd0;
        st_nxt.partial   = 1'b0;
      end
    end else begin
      unique case (ph)
        PH_TAG: begin
          st_nxt.total = 32'd0;
          if (!data_byte[7] || (!data_byte[6] && data_byte[1:0] == 2'd3)) begin
            st_nxt.remaining = 32'd0;
            st_nxt.acc       = 32'd0;
            st_nxt.left      = 3'd0;
            st_nxt.partial   = 1'b0;
          end else if (data_byte[6]) begin
            st_nxt.total   = 32'd1;
            st_nxt.phase   = PH_LEN1;
            st_nxt.partial = 1'b0;
          end else begin
            st_nxt.total   = 32'd1;
            st_nxt.partial = 1'b0;
            st_nxt.acc     = 32'd0;
            st_nxt.phase   = PH_LENM;
            case (data_byte[1:0])
              2'd0:    st_nxt.left = 3'd1;
              2'd1:    st_nxt.left = 3'd2;
              default: st_nxt.left = 3'd4;
            endcase
          end
        end
        PH_LEN1: begin
          if (!b_lt192 && b_le223) begin
            st_nxt.acc   = {16'd0, data_byte - 8'd192, 8'd0};
            st_nxt.phase = PH_LEN2;
          end else if (!b_lt255) begin
            st_nxt.acc   = 32'd0;
            st_nxt.left  = 3'd4;
            st_nxt.phase = PH_LENM;
          end
        end
        PH_LEN2: ;
        PH_LENM: begin
          st_nxt.acc  = lenm_acc;
          st_nxt.left = left_dec;
        end
        PH_BODY: begin
          st_nxt.total     = total_inc;
          st_nxt.remaining = rem_dec;
          if (rem_dec == 32'd0)
            st_nxt.phase = st.partial ? PH_LEN1 : PH_TAG;
        end
        default: ;
      endcase
      if (sb_go) begin
        st_nxt.partial = sb_part;
        st_nxt.acc     = 32'd0;
        st_nxt.left    = 3'd0;
        if (sb_end) begin
          st_nxt.phase = PH_TAG;
        end else begin
          st_nxt.remaining = sb_len;
          st_nxt.phase     = (sb_len == 32'd0) ? PH_LEN1 : PH_BODY;
        end
      end
    end
  end

  // result
  always_comb begin
    res_valid = 1'b0;
    res.kind  = OK_ERROR;
    res.data  = 8'd0;
    res.last  = 1'b1;
    res.err   = ERR_NONE;
    res.len   = st_nxt.total;
    if (kind == IN_EOF) begin
      res_valid = (ph != PH_TAG);
      res.err   = ERR_TRUNC;
    end else begin
      unique case (ph)
        PH_TAG: begin
          res_valid = 1'b1;
          if (!data_byte[7]) begin
            res.err = ERR_NO_MARKER;
          end else if (data_byte[6]) begin
            res.kind = OK_TAG;
            res.data = data_byte;
            res.last = 1'b0;
          end else if (data_byte[1:0] == 2'd3) begin
            res.err = ERR_INDET;
          end else begin
            res.kind = OK_TAG;
            res.data = {4'h8, data_byte[5:2]};
            res.last = 1'b0;
          end
        end
        PH_BODY: begin
          res_valid = 1'b1;
          res.kind  = OK_BODY;
          res.data  = data_byte;
          res.last  = (rem_dec == 32'd0) && !st.partial;
        end
        default: begin
          res_valid = sb_end;
          res.kind  = OK_END;
        end
      endcase
    end
  end

endmodule

>>> design/openpgp_packet_deframer_core.sv
// Top level of the OpenPGP packet deframer.
//
// Usage:
//  - in_*  : one request per stream byte. in_tdata carries the raw byte,
//            in_tuser says whether a byte is present (0) or input has ended (1).
//  - out_* : tags, body bytes, empty-packet ends and errors. Length headers
//            are swallowed and produce no request. out_tlast marks the final
//            item of a packet and every error item.
//  - A result is registered and appears in the cycle after its input is taken.
//  - Throughput: one byte per cycle unless stalled. The per-byte decode is one
//    combinational step into a single result register; in_tready follows
//    out_tready, so the register is refilled in the same cycle it drains.
//  - Stall: while out_tready is low and a result is held, in_tready drops;
//    no state moves and the held result stays put.
//  - Reset (rst_n low, synchronous): waits for a tag byte, all counters
//    cleared, output empty.
//  - After any error the block waits for a fresh tag byte.
module openpgp_packet_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] out_byte, [9:8] error_code,
                                  // [41:10] packet_length, [47:42] zero
  output logic [1:0]  out_tuser,  // [1:0] out_kind
  output logic        out_tlast   // last
);
  import pgpd_pkg::*;

  `include "openpgp_packet_deframer_core_defines.svh"

  state_t  state_r, state_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;
  logic    res_valid;
  result_t res;
  logic    accept;

  pgpd_step u_step (
    .st        (state_r),
    .kind      (in_tuser),
    .data_byte (in_tdata),
    .st_nxt    (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    if (accept) begin
      out_valid_nxt = res_valid;
      if (res_valid)
        out_res_nxt = res;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase     <= PH_TAG;
      state_r.remaining <= 32'd0;
      state_r.acc       <= 32'd0;
      state_r.left      <= 3'd0;
      state_r.partial   <= 1'b0;
      state_r.total     <= 32'd0;
      out_valid_r       <= 1'b0;
    end else begin
      if (accept)
        state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {6'd0, out_res_r.len, out_res_r.err, out_res_r.data};

  `PGPD_ASSERT_IMPL(a_err_marks_last,
    out_tvalid && out_tuser == OK_ERROR,
    out_tlast && out_tdata[9:8] != ERR_NONE,
    "error item without last or code")
  `PGPD_ASSERT_IMPL(a_code_only_on_err,
    out_tvalid && out_tuser != OK_ERROR,
    out_tdata[9:8] == ERR_NONE,
    "error code on a non-error item")
  `PGPD_ASSERT_IMPL(a_tag_len_one,
    out_tvalid && out_tuser == OK_TAG,
    out_tdata[41:10] == 32'd1 && !out_tlast,
    "tag item with wrong length or last")
  `PGPD_ASSERT_NEXT(a_err_back_to_tag,
    accept && res_valid && res.kind == OK_ERROR,
    state_r.phase == PH_TAG,
    "not waiting for a tag after an error")

endmodule

>>> test/tb_deframer_pkg.sv
// Scoreboard for the OpenPGP packet deframer testbench: predicts results and checks them.
`timescale 1ns / 1ps

package tb_deframer_pkg;
  import pgpd_pkg::*;

  class pgp_frame_scoreboard;
    phase_t      ph;
    logic [31:0] body_left;
    logic [31:0] len_acc;
    logic [2:0]  hdr_left;
    logic        in_partial;
    logic [31:0] pkt_bytes;
    result_t     expected_q[$];
    int unsigned requests;
    int unsigned results;
    int unsigned mismatches;
    int unsigned kind_seen[4];

    function new();
      ph         = PH_TAG;
      body_left  = '0;
      len_acc    = '0;
      hdr_left   = '0;
      in_partial = 1'b0;
      pkt_bytes  = '0;
      requests   = 0;
      results    = 0;
      mismatches = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void push(out_kind_t k, logic [7:0] d, logic l, err_code_t e);
      result_t r;
      r.kind = k;
      r.data = d;
      r.last = l;
      r.err  = e;
      r.len  = pkt_bytes;
      expected_q.push_back(r);
    endfunction

    // Error item, then back to hunting for a tag; byte count is kept for the item.
    function void raise_error(err_code_t e);
      push(OK_ERROR, 8'h00, 1'b1, e);
      ph         = PH_TAG;
      body_left  = '0;
      len_acc    = '0;
      hdr_left   = '0;
      in_partial = 1'b0;
    endfunction

    // Length known: empty final chunk ends the packet, otherwise start the body.
    function void begin_body(logic [31:0] n, logic part);
      in_partial = part;
      len_acc    = '0;
      hdr_left   = '0;
      if (n == 0 && !part) begin
        ph = PH_TAG;
        push(OK_END, 8'h00, 1'b1, ERR_NONE);
      end else begin
        body_left = n;
        ph = (n == 0) ? PH_LEN1 : PH_BODY;
      end
    endfunction

    function void note_request(logic eoi, logic [7:0] b);
      requests++;
      if (eoi == IN_EOF) begin
        if (ph != PH_TAG) raise_error(ERR_TRUNC);
        return;
      end
      case (ph)
        PH_TAG: begin
          pkt_bytes = '0;
          if (!b[7]) begin
            raise_error(ERR_NO_MARKER);
          end else if (b[6]) begin
            pkt_bytes  = 32'd1;
            in_partial = 1'b0;
            ph         = PH_LEN1;
            push(OK_TAG, b, 1'b0, ERR_NONE);
          end else if (b[1:0] == 2'b11) begin
            raise_error(ERR_INDET);
          end else begin
            pkt_bytes  = 32'd1;
            in_partial = 1'b0;
            len_acc    = '0;
            hdr_left   = (b[1:0] == 2'b00) ? 3'd1 : (b[1:0] == 2'b01) ? 3'd2 : 3'd4;
            ph         = PH_LENM;
            push(OK_TAG, {4'h8, b[5:2]}, 1'b0, ERR_NONE);
          end
        end
        PH_LEN1: begin
          if (b < 8'd192) begin
            begin_body(32'(b), 1'b0);
          end else if (b <= 8'd223) begin
            len_acc = (32'(b) - 32'd192) * 32'd256;
            ph      = PH_LEN2;
          end else if (b < 8'd255) begin
            begin_body(32'd1 << b[4:0], 1'b1);
          end else begin
            len_acc  = '0;
            hdr_left = 3'd4;
            ph       = PH_LENM;
          end
        end
        PH_LEN2: begin_body(len_acc + 32'(b) + 32'd192, 1'b0);
        PH_LENM: begin
          len_acc  = {len_acc[23:0], b};
          hdr_left = hdr_left - 3'd1;
          if (hdr_left == 0) begin_body(len_acc, 1'b0);
        end
        default: begin
          if (pkt_bytes != LEN_SAT) pkt_bytes++;
          body_left--;
          if (body_left != 0) begin
            push(OK_BODY, b, 1'b0, ERR_NONE);
          end else if (in_partial) begin
            ph = PH_LEN1;
            push(OK_BODY, b, 1'b0, ERR_NONE);
          end else begin
            ph = PH_TAG;
            push(OK_BODY, b, 1'b1, ERR_NONE);
          end
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kind=%0d byte=%02h last=%0b err=%0d len=%0d",
                 $time, got.kind, got.data, got.last, got.err, got.len);
        return;
      end
      want = expected_q.pop_front();
      results++;
      kind_seen[got.kind]++;
      if (got !== want) begin
        mismatches++;
        $display("%0t: result %0d expected kind=%0d byte=%02h last=%0b err=%0d len=%0d",
                 $time, results, want.kind, want.data, want.last, want.err, want.len);
        $display("%0t: result %0d actual   kind=%0d byte=%02h last=%0b err=%0d len=%0d",
                 $time, results, got.kind, got.data, got.last, got.err, got.len);
      end
    endfunction
  endclass

endpackage

>>> test/tb_top.sv
// Top-level testbench for the OpenPGP packet deframer: stimulus, handshakes and end of run.
`timescale 1ns / 1ps

module tb_top;
  import pgpd_pkg::*;
  import tb_deframer_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tuser = IN_BYTE; // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;          // [7:0] out_byte, [9:8] error_code, [41:10] packet_length
  logic [1:0]  out_tuser;          // [1:0] out_kind
  logic        out_tlast;

  // One stream request: a byte, or the end-of-input marker.
  typedef struct {
    logic       eoi;
    logic [7:0] b;
  } stream_item_t;

  stream_item_t        stream_q[$];
  pgp_frame_scoreboard sb;
  int unsigned         items_sent = 0;
  int unsigned         src_idle_pct = 0;
  int unsigned         sink_idle_pct = 0;
  int unsigned         hold_req = 0;  // long output hold-off asked for by the sender side
  int unsigned         hold_left = 0;

  openpgp_packet_deframer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or a result never turns up.
  initial begin
    #3_000_000;
    $display("FAIL openpgp_packet_deframer_core");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off counted here so that the
  // single result register fills and the block pushes back on its input.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Monitor: every accepted result goes to the scoreboard, oldest expectation first.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_kind_t'(out_tuser);
      got.data = out_tdata[7:0];
      got.last = out_tlast;
      got.err  = err_code_t'(out_tdata[9:8]);
      got.len  = out_tdata[41:10];
      sb.check_result(got);
    end
  end

  // ---- stream building ----

  function automatic void add_byte(logic [7:0] b);
    stream_item_t it;
    it.eoi = IN_BYTE;
    it.b   = b;
    stream_q.push_back(it);
  endfunction

  // End of input; the byte lane carries junk that must be ignored.
  function automatic void add_eoi();
    stream_item_t it;
    it.eoi = IN_EOF;
    it.b   = 8'($urandom_range(255));
    stream_q.push_back(it);
  endfunction

  function automatic void add_body(int unsigned n);
    repeat (n) add_byte(8'($urandom_range(255)));
  endfunction

  // Big-endian length field of nbytes bytes.
  function automatic void add_word(int unsigned n, int unsigned nbytes);
    for (int i = int'(nbytes) - 1; i >= 0; i--) add_byte(8'(n >> (8 * i)));
  endfunction

  // Mostly short bodies, the odd long one.
  function automatic int unsigned short_len(int unsigned max_len);
    return ($urandom_range(9) == 0) ? $urandom_range(0, max_len) : $urandom_range(0, 12);
  endfunction

  // One well-formed packet with random format, length encoding and content.
  function automatic void gen_packet();
    int unsigned n;
    int unsigned e;
    int unsigned nparts;
    int unsigned form;
    int unsigned lt;
    if ($urandom_range(99) < 60) begin
      add_byte(8'hC0 | 8'($urandom_range(63)));
      // partial chunks first now and then, each needing a further header
      nparts = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (nparts) begin
        e = $urandom_range(0, 4);
        add_byte(8'(224 + e));
        add_body(1 << e);
      end
      form = $urandom_range(0, 9);
      if (form < 6) begin
        n = short_len(191);
        add_byte(8'(n));
      end else if (form < 8) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(192, 1200) : $urandom_range(192, 215);
        add_byte(8'(192 + ((n - 192) >> 8)));
        add_byte(8'(n - 192));
      end else begin
        n = short_len(300);
        add_byte(8'hFF);
        add_word(n, 4);
      end
      add_body(n);
    end else begin
      lt = $urandom_range(0, 2);
      add_byte(8'h80 | 8'($urandom_range(15) << 2) | 8'(lt));
      n = short_len((lt == 0) ? 255 : 600);
      add_word(n, (lt == 0) ? 1 : (lt == 1) ? 2 : 4);
      add_body(n);
    end
  endfunction

  // Broken input: bad markers, indeterminate lengths, cut packets, garbage.
  function automatic void gen_noise();
    int unsigned start;
    int unsigned cut;
    case ($urandom_range(0, 3))
      0: add_byte(8'($urandom_range(127)));
      1: add_byte(8'h83 | 8'($urandom_range(15) << 2));
      2: begin
        start = stream_q.size();
        gen_packet();
        cut = $urandom_range(1, stream_q.size() - start - 1);
        while (stream_q.size() > start + cut) void'(stream_q.pop_back());
        add_eoi();
      end
      default: begin
        add_body($urandom_range(1, 4));
        add_eoi();  // resync whatever the garbage started
      end
    endcase
  endfunction

  // ---- driving ----

  // Entered and left at a falling edge; in_tvalid stays high when the next
  // request follows at once, so it is never lowered and raised in one step.
  task automatic send_request(logic eoi, logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= eoi;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_request(eoi, b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic play_stream();
    stream_item_t it;
    while (stream_q.size() != 0) begin
      it = stream_q.pop_front();
      send_request(it.eoi, it.b);
    end
  endtask

  // Sender pauses until every expected result has come out; always leaves at a
  // later falling edge than the one it lowered in_tvalid on.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_random(int unsigned n_items, int unsigned src_pct,
                            int unsigned sink_pct, bit with_hold);
    int unsigned stop_at;
    bit          held;
    stop_at       = items_sent + n_items;
    held          = 1'b0;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    while (items_sent < stop_at) begin
      if (with_hold && !held && items_sent + n_items / 2 >= stop_at) begin
        hold_req = 150;
        held     = 1'b1;
      end
      if ($urandom_range(99) < 80) gen_packet();
      else gen_noise();
      if ($urandom_range(15) == 0) add_eoi();  // clean end between packets
      play_stream();
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: clean end, missing marker, indeterminate length, empty packet,
    // old one-byte and two-byte lengths, a partial chunk, a five-byte maximal
    // length cut short, a huge partial chunk cut short.
    add_eoi();
    add_byte(8'h00);
    add_byte(8'hBF);
    add_byte(8'hFF); add_byte(8'h00);
    add_byte(8'h80); add_byte(8'h01); add_byte(8'hAA);
    add_byte(8'h85); add_byte(8'h00); add_byte(8'h00);
    add_byte(8'hC0); add_byte(8'hE0); add_byte(8'h11); add_byte(8'h01); add_byte(8'hEE);
    add_byte(8'hC1); add_byte(8'hFF); add_word(32'hFFFF_FFFF, 4); add_byte(8'h7E); add_eoi();
    add_byte(8'hC3); add_byte(8'hFE); add_byte(8'h5A); add_eoi();
    play_stream();
    wait_drained();

    // Random: fast sender / busy receiver, then the reverse, then full rate
    // with one long output hold-off.
    run_random(500, 17, 74, 1'b0);
    run_random(500, 74, 17, 1'b0);
    run_random(500, 0, 0, 1'b1);

    sink_idle_pct = 0;
    wait_drained();
    repeat (4) @(posedge clk);

    $display("Sent %0d requests (directed, random packets, broken streams); %0d results checked",
             sb.requests, sb.results);
    $display("Results by kind: %0d tag, %0d body, %0d empty end, %0d error",
             sb.kind_seen[OK_TAG], sb.kind_seen[OK_BODY], sb.kind_seen[OK_END],
             sb.kind_seen[OK_ERROR]);
    if (sb.mismatches == 0) begin
      $display("PASS openpgp_packet_deframer_core");
    end else begin
      $display("FAIL openpgp_packet_deframer_core");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/pgpd_pkg.sv
design/pgpd_step.sv
design/openpgp_packet_deframer_core.sv
test/tb_deframer_pkg.sv
test/tb_top.sv
